// ----- rtl/core/rmf_pkg.sv -----
`default_nettype none

package rmf_pkg;

    // default configuration of the filter
    localparam int MAX_HALF_WINDOW = 16;
    localparam int SAMPLE_BITS     = 24;

    // register file
    localparam int        HW_W           = 5;
    localparam logic [HW_W-1:0] HW_RESET = 5'd2;
    localparam int        APB_ADDR_W     = 3;
    localparam int        APB_DATA_W     = 32;
    // register index is paddr[2] (byte address 4*i)
    localparam logic      REG_HALF_WINDOW = 1'b0;

    // sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_COUNT,
        ST_PICK,
        ST_EMIT
    } state_t;

    // command group from the sequencer to every cell
    typedef struct packed {
        logic shift;   // new sample enters cell 0, all samples age by one
        logic load;    // copy line takes the stored samples, ranks clear
        logic count;   // copy line moves one cell down, ranks update
        logic pick;    // cells holding the middle ranks present their sample
    } cell_cmd_t;

endpackage

`default_nettype wire

// ----- rtl/core/running_median_filter_top.sv -----
// channel    | direction | payload                       | handshake
// s_axis     | in        | tdata: sample, tlast: last_in | s_tvalid / s_tready
// m_axis     | out       | tdata: filtered, tlast: last_out | m_tvalid / m_tready
// apb        | in/out    | half_window at byte address 0 | psel, penable, pready
//
// a sample that gives no output is only shifted in; each output runs through the steps
// copy load, one rank update per window sample, pick and emit, cnt <= 2W+1; the
// rank updates come from the copy line walking each window sample past cell 0
// a sample marked last gives up to W+1 outputs back to back in this way
// reset clears the sequencer and the register; cells keep no reset, stale
// entries of an earlier record are never inside a window
// a finished output waits in the output register; input is taken meanwhile
`default_nettype none

module running_median_filter_top #(
    parameter int MAX_HALF_WINDOW = rmf_pkg::MAX_HALF_WINDOW,
    parameter int SAMPLE_BITS     = rmf_pkg::SAMPLE_BITS
) (
    input  wire                                clk,
    input  wire                                rst_n,
    // slave stream
    input  wire                                s_tvalid,
    output logic                               s_tready,
    input  wire  [((SAMPLE_BITS+7)/8)*8-1:0]   s_tdata,   // [SAMPLE_BITS-1:0] sample
    input  wire                                s_tlast,
    // master stream
    output logic                               m_tvalid,
    input  wire                                m_tready,
    output logic [((SAMPLE_BITS+7)/8)*8-1:0]   m_tdata,   // [SAMPLE_BITS-1:0] filtered
    output logic                               m_tlast,
    // configuration
    input  wire                                psel,
    input  wire                                penable,
    input  wire                                pwrite,
    input  wire  [rmf_pkg::APB_ADDR_W-1:0]     paddr,
    input  wire  [rmf_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [rmf_pkg::APB_DATA_W-1:0]     prdata,
    output logic                               pready
);

    localparam int DEPTH   = 2 * MAX_HALF_WINDOW + 1;
    localparam int RANK_W  = $clog2(DEPTH);
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int TDATA_W = ((SAMPLE_BITS + 7) / 8) * 8;

    logic [rmf_pkg::HW_W-1:0] half_window_reg;
    logic                     cfg_write;

    rmf_pkg::cell_cmd_t       cmd;
    logic [CNT_W-1:0]         bcast_idx;
    logic [CNT_W-1:0]         cnt;
    logic [RANK_W-1:0]        rank_lo;
    logic [RANK_W-1:0]        rank_hi;
    logic signed [SAMPLE_BITS-1:0] val_bus  [DEPTH];
    logic signed [SAMPLE_BITS-1:0] copy_bus [DEPTH];
    logic signed [SAMPLE_BITS-1:0] lo_bus   [DEPTH];
    logic signed [SAMPLE_BITS-1:0] hi_bus   [DEPTH];
    logic signed [SAMPLE_BITS-1:0] mid_lo;
    logic signed [SAMPLE_BITS-1:0] mid_hi;
    logic signed [SAMPLE_BITS-1:0] out_data;

    // configuration register
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready &&
                       (paddr[2] == rmf_pkg::REG_HALF_WINDOW);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            half_window_reg <= rmf_pkg::HW_RESET;
        end
        else if (cfg_write)
        begin
            half_window_reg <= pwdata[rmf_pkg::HW_W-1:0];
        end
    end

    assign prdata = (paddr[2] == rmf_pkg::REG_HALF_WINDOW)
                    ? rmf_pkg::APB_DATA_W'(half_window_reg) : '0;

    // chain of sorting cells, newest sample in cell 0
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic signed [SAMPLE_BITS-1:0] sample_in;
        logic signed [SAMPLE_BITS-1:0] copy_in;

        if (i == 0)
        begin : g_head
            assign sample_in = s_tdata[SAMPLE_BITS-1:0];
        end
        else
        begin : g_body
            assign sample_in = val_bus[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_tail
            assign copy_in = '0;
        end
        else
        begin : g_next
            assign copy_in = copy_bus[i+1];
        end

        rmf_cell #(
            .SAMPLE_BITS (SAMPLE_BITS),
            .IDX         (i),
            .RANK_W      (RANK_W),
            .CNT_W       (CNT_W)
        ) u_cell (
            .clk        (clk),
            .cmd        (cmd),
            .sample_in  (sample_in),
            .sample_out (val_bus[i]),
            .copy_in    (copy_in),
            .copy_out   (copy_bus[i]),
            .bcast      (copy_bus[0]),
            .bcast_idx  (bcast_idx),
            .cnt        (cnt),
            .rank_lo    (rank_lo),
            .rank_hi    (rank_hi),
            .pick_lo    (lo_bus[i]),
            .pick_hi    (hi_bus[i])
        );
    end

    // only one cell presents each middle rank, the rest are zero
    always_comb
    begin
        mid_lo = '0;
        mid_hi = '0;
        for (int k = 0; k < DEPTH; k++)
        begin
            mid_lo = mid_lo | lo_bus[k];
            mid_hi = mid_hi | hi_bus[k];
        end
    end

    // sequencer and output register
    rmf_seq #(
        .MAX_HALF_WINDOW (MAX_HALF_WINDOW),
        .SAMPLE_BITS     (SAMPLE_BITS),
        .RANK_W          (RANK_W),
        .CNT_W           (CNT_W)
    ) u_seq (
        .clk         (clk),
        .rst_n       (rst_n),
        .half_window (half_window_reg),
        .in_valid    (s_tvalid),
        .in_last     (s_tlast),
        .in_ready    (s_tready),
        .cmd         (cmd),
        .bcast_idx   (bcast_idx),
        .cnt         (cnt),
        .rank_lo     (rank_lo),
        .rank_hi     (rank_hi),
        .mid_lo      (mid_lo),
        .mid_hi      (mid_hi),
        .out_valid   (m_tvalid),
        .out_data    (out_data),
        .out_last    (m_tlast),
        .out_ready   (m_tready)
    );

    assign m_tdata = TDATA_W'($unsigned(out_data));

endmodule

`default_nettype wire

// ----- rtl/core/rmf_cell.sv -----
`default_nettype none

module rmf_cell #(
    parameter int SAMPLE_BITS = rmf_pkg::SAMPLE_BITS,
    parameter int IDX         = 0,
    parameter int RANK_W      = 6,
    parameter int CNT_W       = 6
) (
    input  wire                          clk,
    input  wire rmf_pkg::cell_cmd_t      cmd,
    input  wire signed [SAMPLE_BITS-1:0] sample_in,
    output logic signed [SAMPLE_BITS-1:0] sample_out,
    input  wire signed [SAMPLE_BITS-1:0] copy_in,
    output logic signed [SAMPLE_BITS-1:0] copy_out,
    input  wire signed [SAMPLE_BITS-1:0] bcast,
    input  wire        [CNT_W-1:0]       bcast_idx,
    input  wire        [CNT_W-1:0]       cnt,
    input  wire        [RANK_W-1:0]      rank_lo,
    input  wire        [RANK_W-1:0]      rank_hi,
    output logic signed [SAMPLE_BITS-1:0] pick_lo,
    output logic signed [SAMPLE_BITS-1:0] pick_hi
);

    localparam logic [CNT_W-1:0] MY_IDX = CNT_W'(IDX);

    logic signed [SAMPLE_BITS-1:0] val_reg;
    logic signed [SAMPLE_BITS-1:0] copy_reg;
    logic        [RANK_W-1:0]      rank_reg;
    logic signed [SAMPLE_BITS-1:0] pick_lo_reg;
    logic signed [SAMPLE_BITS-1:0] pick_hi_reg;
    logic                          active;
    logic                          beats;

    // this cell lies inside the window of the current median
    assign active = MY_IDX < cnt;

    // broadcast sample ranks below ours; equal samples break ties by age
    assign beats = (bcast < val_reg) || ((bcast == val_reg) && (bcast_idx < MY_IDX));

    // age-ordered sample line
    always_ff @(posedge clk)
    begin
        if (cmd.shift)
        begin
            val_reg <= sample_in;
        end
    end

    // copy line that walks every held sample past cell 0
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            copy_reg <= val_reg;
        end
        else if (cmd.count)
        begin
            copy_reg <= copy_in;
        end
    end

    // rank counter
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            rank_reg <= '0;
        end
        else if (cmd.count && beats)
        begin
            rank_reg <= rank_reg + 1'b1;
        end
    end

    // middle rank selection, zero when not chosen so the row can be or-ed
    always_ff @(posedge clk)
    begin
        if (cmd.pick)
        begin
            pick_lo_reg <= (active && (rank_reg == rank_lo)) ? val_reg : '0;
            pick_hi_reg <= (active && (rank_reg == rank_hi)) ? val_reg : '0;
        end
    end

    assign sample_out = val_reg;
    assign copy_out   = copy_reg;
    assign pick_lo    = pick_lo_reg;
    assign pick_hi    = pick_hi_reg;

endmodule

`default_nettype wire

// ----- rtl/core/rmf_seq.sv -----
`default_nettype none

module rmf_seq #(
    parameter int MAX_HALF_WINDOW = rmf_pkg::MAX_HALF_WINDOW,
    parameter int SAMPLE_BITS     = rmf_pkg::SAMPLE_BITS,
    parameter int RANK_W          = 6,
    parameter int CNT_W           = 6
) (
    input  wire                           clk,
    input  wire                           rst_n,
    input  wire  [rmf_pkg::HW_W-1:0]      half_window,
    input  wire                           in_valid,
    input  wire                           in_last,
    output logic                          in_ready,
    output rmf_pkg::cell_cmd_t            cmd,
    output logic [CNT_W-1:0]              bcast_idx,
    output logic [CNT_W-1:0]              cnt,
    output logic [RANK_W-1:0]             rank_lo,
    output logic [RANK_W-1:0]             rank_hi,
    input  wire signed [SAMPLE_BITS-1:0]  mid_lo,
    input  wire signed [SAMPLE_BITS-1:0]  mid_hi,
    output logic                          out_valid,
    output logic signed [SAMPLE_BITS-1:0] out_data,
    output logic                          out_last,
    input  wire                           out_ready
);

    localparam int DEPTH  = 2 * MAX_HALF_WINDOW + 1;
    localparam int CALC_W = ((CNT_W > rmf_pkg::HW_W) ? CNT_W : rmf_pkg::HW_W) + 1;
    localparam logic [CNT_W-1:0]  DEPTH_C = CNT_W'(DEPTH);
    localparam logic [CALC_W-1:0] MAXW_C  = CALC_W'(MAX_HALF_WINDOW);

    rmf_pkg::state_t state_reg, state_next;
    logic [CNT_W-1:0]  seen_reg, seen_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [CNT_W-1:0]  r_reg, r_next;
    logic [CNT_W-1:0]  t_reg, t_next;
    logic              flush_reg, flush_next;
    logic              out_valid_reg, out_valid_next;
    logic signed [SAMPLE_BITS-1:0] out_data_reg, out_data_next;
    logic              out_last_reg, out_last_next;

    logic [CALC_W-1:0] hw_c;
    logic [CALC_W-1:0] eff_c;
    logic [CNT_W-1:0]  seen_inc;
    logic [CALC_W-1:0] seen_inc_c;
    logic [CALC_W-1:0] seen_c;
    logic [CALC_W-1:0] r0_c;
    logic [CALC_W-1:0] flush_cnt_c;
    logic [CALC_W-1:0] full_cnt_c;
    logic [CALC_W-1:0] next_r_c;
    logic [CALC_W-1:0] next_cnt_c;
    logic [CNT_W-1:0]  cnt_m1;
    logic signed [SAMPLE_BITS:0] mid_sum;
    logic signed [SAMPLE_BITS-1:0] median;
    logic              accept;
    logic              out_free;
    logic              out_load;

    // effective half window and window sizes
    always_comb
    begin
        hw_c        = CALC_W'(half_window);
        eff_c       = (hw_c > MAXW_C) ? MAXW_C : hw_c;
        seen_inc    = (seen_reg == DEPTH_C) ? seen_reg : seen_reg + 1'b1;
        seen_inc_c  = CALC_W'(seen_inc);
        seen_c      = CALC_W'(seen_reg);
        r0_c        = (seen_inc_c < eff_c + 1'b1) ? seen_inc_c : eff_c + 1'b1;
        flush_cnt_c = (r0_c + eff_c > seen_inc_c) ? seen_inc_c : r0_c + eff_c;
        full_cnt_c  = ({eff_c[CALC_W-2:0], 1'b1} > seen_inc_c) ? seen_inc_c
                                                               : {eff_c[CALC_W-2:0], 1'b1};
        next_r_c    = CALC_W'(r_reg) - 1'b1;
        next_cnt_c  = (next_r_c + eff_c > seen_c) ? seen_c : next_r_c + eff_c;
    end

    // median from the two middle ranks, floor of the mean
    assign mid_sum = {mid_lo[SAMPLE_BITS-1], mid_lo} + {mid_hi[SAMPLE_BITS-1], mid_hi};
    assign median  = mid_sum[SAMPLE_BITS:1];

    assign cnt_m1  = cnt_reg - 1'b1;
    assign accept  = in_valid && (state_reg == rmf_pkg::ST_IDLE);
    assign out_free = !out_valid_reg || out_ready;
    assign out_load = (state_reg == rmf_pkg::ST_EMIT) && out_free;

    // state and counter registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= rmf_pkg::ST_IDLE;
            seen_reg      <= '0;
            cnt_reg       <= '0;
            r_reg         <= '0;
            t_reg         <= '0;
            flush_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            seen_reg      <= seen_next;
            cnt_reg       <= cnt_next;
            r_reg         <= r_next;
            t_reg         <= t_next;
            flush_reg     <= flush_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // output payload
    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
        out_last_reg <= out_last_next;
    end

    // next state and cell commands
    always_comb
    begin
        state_next     = state_reg;
        seen_next      = seen_reg;
        cnt_next       = cnt_reg;
        r_next         = r_reg;
        t_next         = t_reg;
        flush_next     = flush_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_data_next  = out_data_reg;
        out_last_next  = out_last_reg;
        cmd            = '0;

        case (state_reg)
            rmf_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    cmd.shift = 1'b1;
                    seen_next = seen_inc;
                    if (in_last)
                    begin
                        flush_next = 1'b1;
                        r_next     = r0_c[CNT_W-1:0];
                        cnt_next   = flush_cnt_c[CNT_W-1:0];
                        state_next = rmf_pkg::ST_LOAD;
                    end
                    else if (seen_inc_c > eff_c)
                    begin
                        flush_next = 1'b0;
                        r_next     = CNT_W'(1);
                        cnt_next   = full_cnt_c[CNT_W-1:0];
                        state_next = rmf_pkg::ST_LOAD;
                    end
                end
            end
            rmf_pkg::ST_LOAD:
            begin
                cmd.load   = 1'b1;
                t_next     = '0;
                state_next = rmf_pkg::ST_COUNT;
            end
            rmf_pkg::ST_COUNT:
            begin
                cmd.count = 1'b1;
                t_next    = t_reg + 1'b1;
                if (t_reg == cnt_m1)
                begin
                    state_next = rmf_pkg::ST_PICK;
                end
            end
            rmf_pkg::ST_PICK:
            begin
                cmd.pick   = 1'b1;
                state_next = rmf_pkg::ST_EMIT;
            end
            rmf_pkg::ST_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = median;
                    out_last_next  = flush_reg && (r_reg == CNT_W'(1));
                    if (flush_reg && (r_reg > CNT_W'(1)))
                    begin
                        r_next     = next_r_c[CNT_W-1:0];
                        cnt_next   = next_cnt_c[CNT_W-1:0];
                        state_next = rmf_pkg::ST_LOAD;
                    end
                    else
                    begin
                        if (flush_reg)
                        begin
                            seen_next = '0;
                        end
                        flush_next = 1'b0;
                        state_next = rmf_pkg::ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = rmf_pkg::ST_IDLE;
            end
        endcase
    end

    assign in_ready  = (state_reg == rmf_pkg::ST_IDLE);
    assign bcast_idx = t_reg;
    assign cnt       = cnt_reg;
    assign rank_lo   = RANK_W'(cnt_m1 >> 1);
    assign rank_hi   = RANK_W'(cnt_reg >> 1);
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign out_last  = out_last_reg;

`ifndef SYNTHESIS
    // held sample count never passes the line length
    a_seen_bound: assert property (@(posedge clk) disable iff (!rst_n)
        seen_reg <= DEPTH_C)
        else $error("sample count beyond line length");

    // a median in progress covers at least one and at most the held samples
    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != rmf_pkg::ST_IDLE) |-> ((cnt_reg != '0) && (cnt_reg <= seen_reg)))
        else $error("window size out of range");

    // broadcast never walks past the window
    a_count_idx: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == rmf_pkg::ST_COUNT) |-> (t_reg < cnt_reg))
        else $error("broadcast index past window");

    // the final output of a record leaves the line empty for the next one
    a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (out_load && out_last_next) |=> ((seen_reg == '0) && (state_reg == rmf_pkg::ST_IDLE)))
        else $error("record not closed after final output");
`endif

endmodule

`default_nettype wire
